>>> hdl/page_region_map_table_macros.svh
// Assertion macros for the region map table top level.
`ifndef PAGE_REGION_MAP_TABLE_MACROS_SVH
`define PAGE_REGION_MAP_TABLE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PRMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PRMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/prmt_pkg.sv
// Types, constants and codes of the page region map table.
package prmt_pkg;
  localparam int Entries   = 16;
  localparam int IdxW      = $clog2(Entries);
  localparam int CntW      = IdxW + 2;
  localparam int AddrW     = 48;
  localparam int LenW      = 49;
  localparam int ProtW     = 3;
  localparam int PageLog   = 12;
  localparam int PageBytes = 4096;
  localparam int InDataW   = 152;
  localparam int OutDataW  = 112;

  localparam logic [1:0] FN_RECORD = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [1:0] {CK_IMM, CK_WRITE, CK_LOOK} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [1:0]         status;
    logic               ins;
    logic [AddrW-1:0]   s;
    logic [LenW-1:0]    e;
    logic [AddrW-1:0]   q;
    logic [ProtW-1:0]   rp;
    logic [ProtW-1:0]   cp;
  } cmd_t;
endpackage

>>> hdl/prmt_front.sv
// Front end: accepts input transactions, checks and rounds them into commands.
module prmt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [prmt_pkg::InDataW-1:0]  in_tdata,
  input  logic [1:0]                    in_tuser,
  output logic                          push,
  input  logic                          q_full,
  output prmt_pkg::cmd_t                cmd
);
  logic                         front_v_r;
  prmt_pkg::cmd_t               cmd_r;
  prmt_pkg::cmd_t               cmd_nxt;
  logic [prmt_pkg::AddrW-1:0]   s;
  logic [prmt_pkg::LenW-1:0]    len;
  logic [prmt_pkg::LenW:0]      rnd;
  logic [prmt_pkg::LenW:0]      rlen;
  logic [prmt_pkg::LenW:0]      end_w;
  logic                         misal;
  logic                         over;

  assign s     = in_tdata[47:0];
  assign len   = in_tdata[96:48];
  assign rnd   = {1'b0, len} + 50'(prmt_pkg::PageBytes - 1);
  assign rlen  = {rnd[prmt_pkg::LenW:prmt_pkg::PageLog], {prmt_pkg::PageLog{1'b0}}};
  assign end_w = {2'b00, s} + rlen;
  assign misal = s[prmt_pkg::PageLog-1:0] != '0;
  assign over  = end_w > (50'd1 << prmt_pkg::AddrW);

  always_comb begin
    cmd_nxt.kind   = prmt_pkg::CK_IMM;
    cmd_nxt.status = prmt_pkg::ST_DONE;
    cmd_nxt.ins    = in_tuser == prmt_pkg::FN_RECORD;
    cmd_nxt.s      = s;
    cmd_nxt.e      = end_w[prmt_pkg::LenW-1:0];
    cmd_nxt.q      = in_tdata[150:103];
    cmd_nxt.rp     = in_tdata[99:97];
    cmd_nxt.cp     = in_tdata[102:100];
    if (in_tuser == prmt_pkg::FN_LOOKUP) begin
      cmd_nxt.kind = prmt_pkg::CK_LOOK;
    end else if (in_tuser == prmt_pkg::FN_RECORD || in_tuser == prmt_pkg::FN_REMOVE) begin
      priority if (misal) begin
        cmd_nxt.status = prmt_pkg::ST_BAD;
      end else if (rlen == '0) begin
        cmd_nxt.status = prmt_pkg::ST_DONE;
      end else if (over) begin
        cmd_nxt.status = prmt_pkg::ST_BAD;
      end else begin
        cmd_nxt.kind = prmt_pkg::CK_WRITE;
      end
    end else begin
      cmd_nxt.status = prmt_pkg::ST_BAD;
    end
  end

  assign push      = front_v_r && !q_full;
  assign in_tready = !front_v_r || !q_full;
  assign cmd       = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (in_tready) begin
      front_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      cmd_r <= cmd_nxt;
    end
  end
endmodule

>>> hdl/prmt_queue.sv
// Two-entry command queue between the front end and the table engine.
module prmt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  prmt_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output prmt_pkg::cmd_t rd_cmd
);
  prmt_pkg::cmd_t mem_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;

  assign full     = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wr_cmd;
  end
endmodule

>>> hdl/prmt_back.sv
// Table engine: walks the region slots to look up, count and rewrite regions.
module prmt_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  prmt_pkg::cmd_t                 q_cmd,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [prmt_pkg::OutDataW-1:0]  out_tdata
);
  typedef enum logic [2:0] {S_IDLE, S_COUNT, S_APPLY, S_TAIL, S_INSERT, S_LOOK, S_RESP} state_t;

  state_t                       state_r;
  prmt_pkg::cmd_t               cmd_r;
  logic [prmt_pkg::IdxW-1:0]    idx_r;
  logic [prmt_pkg::CntW-1:0]    cnt_r;
  logic [prmt_pkg::Entries-1:0] valid_r;
  logic [prmt_pkg::AddrW-1:0]   base_r [prmt_pkg::Entries];
  logic [prmt_pkg::LenW-1:0]    len_r  [prmt_pkg::Entries];
  logic [prmt_pkg::ProtW-1:0]   rpr_r  [prmt_pkg::Entries];
  logic [prmt_pkg::ProtW-1:0]   cpr_r  [prmt_pkg::Entries];
  logic                         tail_v_r;
  logic [prmt_pkg::LenW-1:0]    tail_b_r;
  logic [prmt_pkg::LenW-1:0]    tail_l_r;
  logic [prmt_pkg::ProtW-1:0]   tail_rp_r;
  logic [prmt_pkg::ProtW-1:0]   tail_cp_r;
  logic [1:0]                   st_r;
  logic                         hit_r;
  logic [prmt_pkg::AddrW-1:0]   fb_r;
  logic [prmt_pkg::LenW-1:0]    fl_r;
  logic [prmt_pkg::ProtW-1:0]   frp_r;
  logic [prmt_pkg::ProtW-1:0]   fcp_r;

  logic [prmt_pkg::AddrW-1:0]   cb;
  logic [prmt_pkg::LenW-1:0]    cl;
  logic [prmt_pkg::LenW-1:0]    cend;
  logic [prmt_pkg::LenW-1:0]    s49;
  logic                         overl;
  logic                         head;
  logic                         tail;
  logic [1:0]                   pcs;
  logic [prmt_pkg::CntW-1:0]    tot;
  logic [prmt_pkg::AddrW-1:0]   qoff;
  logic                         qhit;
  logic [prmt_pkg::IdxW-1:0]    free_idx;
  logic                         last;

  assign cb    = base_r[idx_r];
  assign cl    = len_r[idx_r];
  assign cend  = {1'b0, cb} + cl;
  assign s49   = {1'b0, cmd_r.s};
  assign overl = !(cend <= s49 || {1'b0, cb} >= cmd_r.e);
  assign head  = {1'b0, cb} < s49;
  assign tail  = cend > cmd_r.e;
  assign last  = idx_r == prmt_pkg::IdxW'(prmt_pkg::Entries - 1);
  assign qoff  = cmd_r.q - cb;
  assign qhit  = valid_r[idx_r] && cmd_r.q >= cb && {1'b0, qoff} < cl;

  always_comb begin
    pcs = 2'd0;
    if (valid_r[idx_r]) begin
      pcs = overl ? 2'(head) + 2'(tail) : 2'd1;
    end
    tot = cnt_r + prmt_pkg::CntW'(pcs) + prmt_pkg::CntW'(cmd_r.ins);
  end

  // Lowest free slot; the count pass guarantees one exists when it is used.
  always_comb begin
    free_idx = '0;
    for (int i = prmt_pkg::Entries - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = prmt_pkg::IdxW'(i);
    end
  end

  assign pop        = state_r == S_IDLE && q_valid;
  assign out_tvalid = state_r == S_RESP;
  assign out_tdata  = {6'd0, fcp_r, frp_r, fl_r, fb_r, hit_r, st_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r    <= q_cmd;
            idx_r    <= '0;
            cnt_r    <= '0;
            tail_v_r <= 1'b0;
            st_r     <= q_cmd.status;
            hit_r    <= 1'b0;
            fb_r     <= '0;
            fl_r     <= '0;
            frp_r    <= '0;
            fcp_r    <= '0;
            unique case (q_cmd.kind)
              prmt_pkg::CK_IMM:   state_r <= S_RESP;
              prmt_pkg::CK_WRITE: state_r <= S_COUNT;
              prmt_pkg::CK_LOOK:  state_r <= S_LOOK;
              default:            state_r <= S_RESP;
            endcase
          end
        end
        S_COUNT: begin
          cnt_r <= cnt_r + prmt_pkg::CntW'(pcs);
          idx_r <= idx_r + prmt_pkg::IdxW'(1);
          if (last) begin
            if (tot > prmt_pkg::CntW'(prmt_pkg::Entries)) begin
              st_r    <= prmt_pkg::ST_FULL;
              state_r <= S_RESP;
            end else begin
              state_r <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          if (valid_r[idx_r] && overl) begin
            if (head) begin
              len_r[idx_r] <= s49 - {1'b0, cb};
              if (tail) begin
                // A region that strictly contains the new one keeps its head
                // in place; the tail is parked and written after the pass.
                tail_v_r  <= 1'b1;
                tail_b_r  <= cmd_r.e;
                tail_l_r  <= cend - cmd_r.e;
                tail_rp_r <= rpr_r[idx_r];
                tail_cp_r <= cpr_r[idx_r];
              end
            end else if (tail) begin
              base_r[idx_r] <= cmd_r.e[prmt_pkg::AddrW-1:0];
              len_r[idx_r]  <= cend - cmd_r.e;
            end else begin
              valid_r[idx_r] <= 1'b0;
            end
          end
          idx_r <= idx_r + prmt_pkg::IdxW'(1);
          if (last) state_r <= S_TAIL;
        end
        S_TAIL: begin
          if (tail_v_r) begin
            valid_r[free_idx] <= 1'b1;
            base_r[free_idx]  <= tail_b_r[prmt_pkg::AddrW-1:0];
            len_r[free_idx]   <= tail_l_r;
            rpr_r[free_idx]   <= tail_rp_r;
            cpr_r[free_idx]   <= tail_cp_r;
          end
          state_r <= S_INSERT;
        end
        S_INSERT: begin
          if (cmd_r.ins) begin
            valid_r[free_idx] <= 1'b1;
            base_r[free_idx]  <= cmd_r.s;
            len_r[free_idx]   <= cmd_r.e - s49;
            rpr_r[free_idx]   <= cmd_r.rp;
            cpr_r[free_idx]   <= cmd_r.cp;
          end
          state_r <= S_RESP;
        end
        S_LOOK: begin
          idx_r <= idx_r + prmt_pkg::IdxW'(1);
          if (qhit) begin
            hit_r   <= 1'b1;
            fb_r    <= cb;
            fl_r    <= cl;
            frp_r   <= rpr_r[idx_r];
            fcp_r   <= cpr_r[idx_r];
            state_r <= S_RESP;
          end else if (last) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/page_region_map_table.sv
// Top level of the page region map table.
// The block keeps up to 16 non-overlapping page-aligned regions (4 KiB pages).
// Input channel in_*: in_tuser carries the function (record, remove, look up),
// in_tdata the region start, length, both protections and the query address.
// Each input transaction gives exactly one result transaction on out_*.
// A transaction is checked and rounded in the front stage, then waits in a
// two-entry queue until the table engine takes it.
// The engine visits one slot per clock. A lookup walks the slots in the engine,
// stopping at the hit; a record or remove makes a counting pass over all slots,
// then, unless the table would overflow, a rewrite pass and the placing of a
// split tail and the new region. Rejected or zero-length requests pass straight
// to the result register. The engine takes one transaction at a time and pops
// the next only after its result has been accepted.
// Reset empties the table and the queue; no clearing pass is needed.
// While the receiver stalls, the result holds and the front keeps accepting
// until the queue and the front stage are full.
`include "page_region_map_table_macros.svh"
module page_region_map_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // start[47:0], length[96:48], prot_req[99:97], prot_cur[102:100], query[150:103]
  input  logic [prmt_pkg::InDataW-1:0]  in_tdata,
  // func[1:0]
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // status[1:0], hit[2], base[50:3], length[99:51], prot_req[102:100], prot_cur[105:103]
  output logic [prmt_pkg::OutDataW-1:0] out_tdata
);
  prmt_pkg::cmd_t f_cmd;
  prmt_pkg::cmd_t q_cmd;
  logic           push;
  logic           q_full;
  logic           pop;
  logic           q_valid;

  prmt_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .push, .q_full, .cmd(f_cmd)
  );

  prmt_queue u_queue (
    .clk, .rst_n, .push, .wr_cmd(f_cmd), .full(q_full),
    .pop, .rd_valid(q_valid), .rd_cmd(q_cmd)
  );

  prmt_back u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .pop, .out_tvalid, .out_tready, .out_tdata
  );

  `PRMT_ASSERT_NOW(a_status_code, out_tvalid, out_tdata[1:0] != 2'd3, "status code out of range")
  `PRMT_ASSERT_NOW(a_hit_done, out_tvalid && out_tdata[2], out_tdata[1:0] == prmt_pkg::ST_DONE, "hit with failing status")
  `PRMT_ASSERT_NOW(a_miss_zero, out_tvalid && !out_tdata[2], out_tdata[99:3] == '0, "miss with nonzero region")
  `PRMT_ASSERT_NEXT(a_no_overrun, q_full && !pop, q_full, "queue lost an entry")
endmodule

>>> tb/page_region_map_table_tb.sv
// Testbench for the page region map table: directed and random region traffic checked against a behavioral table.
module page_region_map_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LIMIT_CYCLES = 600000;
  localparam logic [48:0] SPAN = 49'h1_0000_0000_0000;
  localparam logic [1:0] FN_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0]  cp;
    logic [2:0]  rp;
    logic [48:0] len;
    logic [47:0] base;
    logic        hit;
    logic [1:0]  status;
  } map_result_t;

  typedef struct {
    logic [47:0] base;
    logic [48:0] len;
    logic [2:0]  rp;
    logic [2:0]  cp;
  } region_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [prmt_pkg::InDataW-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [prmt_pkg::OutDataW-1:0] out_tdata;

  region_t     table_now[$];
  map_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  bit drain_mode = 1'b0;

  page_region_map_table DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Applies one request to the behavioral table and returns its expected result.
  function automatic map_result_t predict_region_op(logic [1:0] fn, logic [47:0] s,
      logic [48:0] l, logic [2:0] rp, logic [2:0] cp, logic [47:0] q);
    map_result_t r;
    region_t kept[$];
    region_t piece;
    logic [49:0] ln, e, rend;
    r = '0;
    if (fn == prmt_pkg::FN_LOOKUP) begin
      foreach (table_now[k])
        if (q >= table_now[k].base && q - table_now[k].base < table_now[k].len) begin
          r.hit = 1'b1;
          r.base = table_now[k].base;
          r.len = table_now[k].len;
          r.rp = table_now[k].rp;
          r.cp = table_now[k].cp;
          break;
        end
      return r;
    end
    if (fn != prmt_pkg::FN_RECORD && fn != prmt_pkg::FN_REMOVE) begin
      r.status = prmt_pkg::ST_BAD;
      return r;
    end
    if (s[11:0] != 0) begin
      r.status = prmt_pkg::ST_BAD;
      return r;
    end
    ln = ({1'b0, l} + 50'd4095) & ~50'd4095;
    if (ln == 0) return r;
    if (ln > {2'b0, SPAN} - s) begin
      r.status = prmt_pkg::ST_BAD;
      return r;
    end
    e = s + ln;
    foreach (table_now[k]) begin
      rend = table_now[k].base + table_now[k].len;
      if (rend <= s || table_now[k].base >= e) begin
        kept.push_back(table_now[k]);
        continue;
      end
      if (table_now[k].base < s) begin
        piece = table_now[k];
        piece.len = 49'(s - table_now[k].base);
        kept.push_back(piece);
      end
      if (rend > e) begin
        piece = table_now[k];
        piece.base = e[47:0];
        piece.len = 49'(rend - e);
        kept.push_back(piece);
      end
    end
    if (fn == prmt_pkg::FN_RECORD) begin
      piece.base = s;
      piece.len = ln[48:0];
      piece.rp = rp;
      piece.cp = cp;
      kept.push_back(piece);
    end
    if (kept.size() > prmt_pkg::Entries) begin
      r.status = prmt_pkg::ST_FULL;
      return r;
    end
    table_now = kept;
    return r;
  endfunction

  task automatic send_request(logic [1:0] fn, logic [47:0] s, logic [48:0] l,
      logic [2:0] rp, logic [2:0] cp, logic [47:0] q);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {1'b0, q, cp, rp, l, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_region_op(fn, s, l, rp, cp, q));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    map_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[105:0];
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.hit != want.hit) begin
          $error("hit exp %0d got %0d", want.hit, got.hit); errors++;
        end
        if (got.base != want.base) begin
          $error("found_base exp %h got %h", want.base, got.base); errors++;
        end
        if (got.len != want.len) begin
          $error("found_length exp %h got %h", want.len, got.len); errors++;
        end
        if (got.rp != want.rp) begin
          $error("found_requested_protection exp %0d got %0d", want.rp, got.rp); errors++;
        end
        if (got.cp != want.cp) begin
          $error("found_current_protection exp %0d got %0d", want.cp, got.cp); errors++;
        end
      end
    end
  end

  // Receiver: random ready, occasional short holds and long holds on request.
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_cycles <= 300;
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (drain_mode) out_tready <= 1'b1;
    else if ($urandom_range(0, 29) == 0) begin
      hold_cycles <= $urandom_range(10, 60);
      out_tready <= 1'b0;
    end else out_tready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [47:0] page_addr(int maxpage);
    return 48'($urandom_range(0, maxpage)) << 12;
  endfunction

  task automatic test_directed();
    send_request(prmt_pkg::FN_LOOKUP, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF);
    send_request(prmt_pkg::FN_RECORD, 48'h1000, 49'h3000, 3'd7, 3'd5, '0);
    send_request(prmt_pkg::FN_LOOKUP, '0, '0, '0, '0, 48'h2FFF);
    send_request(prmt_pkg::FN_RECORD, 48'h2000, 49'h1, 3'd1, 3'd2, '0);  // split inside
    send_request(prmt_pkg::FN_LOOKUP, '0, '0, '0, '0, 48'h3000);
    send_request(prmt_pkg::FN_LOOKUP, '0, '0, '0, '0, 48'h1000);
    send_request(prmt_pkg::FN_RECORD, 48'h1001, 49'h1000, 3'd0, 3'd0, '0);  // misaligned
    send_request(prmt_pkg::FN_RECORD, 48'h5000, 49'h0, 3'd3, 3'd3, '0);     // zero length
    send_request(prmt_pkg::FN_RECORD, 48'hFFFF_FFFF_F000, 49'h2000, 3'd3, 3'd3, '0);  // past top
    send_request(prmt_pkg::FN_RECORD, 48'hFFFF_FFFF_F000, 49'h1000, 3'd6, 3'd1, '0);
    send_request(prmt_pkg::FN_LOOKUP, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF);
    send_request(prmt_pkg::FN_RECORD, 48'h0, 49'h1_0000_0000_0000, 3'd7, 3'd7, '0);  // whole space
    send_request(prmt_pkg::FN_LOOKUP, '0, '0, '0, '0, 48'h8000_0000_0000);
    send_request(prmt_pkg::FN_REMOVE, 48'h4000, 49'h2000, '0, '0, '0);
    send_request(prmt_pkg::FN_LOOKUP, '0, '0, '0, '0, 48'h4000);
    send_request(prmt_pkg::FN_RECORD, 48'h0, 49'h1_FFFF_FFFF_FFFF, '0, '0, '0);  // length max
    send_request(FN_UNKNOWN, 48'hFFFF_FFFF_FFFF, 49'h1_FFFF_FFFF_FFFF, 3'd7, 3'd7,
                 48'hFFFF_FFFF_FFFF);
    send_request(prmt_pkg::FN_REMOVE, 48'h0, 49'h1_0000_0000_0000, '0, '0, '0);
    // Fill the table with single pages, then overflow it.
    for (int k = 0; k < prmt_pkg::Entries + 1; k++)
      send_request(prmt_pkg::FN_RECORD, 48'(k) << 13, 49'h1000, 3'(k), 3'(~k), '0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [1:0] fn;
    logic [47:0] s, q;
    logic [48:0] l;
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      fn = (pick < 40) ? prmt_pkg::FN_RECORD : (pick < 55) ? prmt_pkg::FN_REMOVE :
           (pick < 97) ? prmt_pkg::FN_LOOKUP : FN_UNKNOWN;
      s = page_addr(63);
      l = 49'($urandom_range(0, 12 * 4096));
      q = 48'($urandom_range(0, 70 * 4096));
      if ($urandom_range(0, 19) == 0) begin
        s = 48'({$urandom, $urandom});
        l = 49'({$urandom, $urandom});
        q = 48'({$urandom, $urandom});
      end else if ($urandom_range(0, 19) == 0) begin
        s = {$urandom_range(0, 1) ? 20'hFFFFF : 20'($urandom), 28'h0};
        l = 49'(($urandom_range(1, 4)) << 12);
        q = s + 48'($urandom_range(0, 4000));
      end
      send_request(fn, s, l, 3'($urandom), 3'($urandom), q);
    end
  endtask

  task automatic test_backpressure();
    hold_requests++;
    for (int k = 0; k < 12; k++)
      send_request(prmt_pkg::FN_LOOKUP, '0, '0, '0, '0, 48'(k) << 12);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(600);
    test_backpressure();
    wait_drained();
    test_random(600);
    drain_mode = 1'b1;
    test_random(150);
    wait_drained();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
